/* rtl/core/ppu_pkg.sv */
// Shared constants and types for the pole projection pipeline.
// Used by every module of the block; depends on nothing else.
package ppu_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int SATV      = (ONE > 32767) ? 32767 : ONE;
    localparam int SAT_SQ    = SATV * SATV;

    // Quotient width of the divider, root width of the square root.
    localparam int QW  = $clog2(SAT_SQ);
    localparam int RW  = (QW + 1) / 2;
    localparam int RMW = RW + 2;

    localparam int NW = 64;   // dividend
    localparam int DW = 33;   // divisor
    localparam int MW = 16;   // component magnitude

    localparam longint L3_AXIS = longint'(ONE) * longint'(ONE) * 2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    typedef struct packed {
        logic hidden;
        logic mode;
        logic axis;
        logic sat_x;
        logic sat_y;
        logic neg_x;
        logic neg_y;
    } ctl_t;

    typedef struct packed {
        ctl_t            c;
        logic [MW-1:0]   wx;
        logic [MW-1:0]   wy;
    } side_t;

endpackage

/* rtl/core/ppu_front.sv */
// Front stages: magnitudes, squares, l2/l3, dividend and divisor, saturation test.
// Depends on ppu_pkg.
module ppu_front
    import ppu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [15:0]   dir_x,
    input  logic signed [15:0]   dir_y,
    input  logic signed [15:0]   dir_z,
    input  logic                 mode,
    input  logic [10:0]          tol,
    output logic                 out_valid,
    output ctl_t                 out_ctl,
    output logic [NW-1:0]        num_x,
    output logic [NW-1:0]        num_y,
    output logic [DW-1:0]        den
);

    localparam logic [16:0] ONE_V = 17'(ONE);

    logic [4:0] vld_reg;

    // stage 1
    logic [MW-1:0] ax_next, ay_next, az_next, d_next;
    logic          hid_next;
    logic [MW-1:0] ax_reg, ay_reg, az_reg, d_reg;
    logic          hid1_reg, mode1_reg, zz1_reg, nx1_reg, ny1_reg;

    // stage 2
    logic [31:0]   a2x_reg, a2y_reg, d2_reg;
    logic [NW-1:0] wnx_reg, wny_reg;
    logic [16:0]   wden_reg;
    logic          hid2_reg, mode2_reg, zz2_reg, nx2_reg, ny2_reg;
    logic [16:0]   wden_next;

    // stage 3
    logic [32:0]   l2_next;
    logic [32:0]   l3_reg, l2_reg;
    logic [31:0]   a2x3_reg, a2y3_reg;
    logic [NW-1:0] wnx3_reg, wny3_reg;
    logic [16:0]   wden3_reg;
    logic          hid3_reg, mode3_reg, nx3_reg, ny3_reg;

    // stage 4
    logic [65:0]   px_prod, py_prod;
    logic [NW-1:0] n4x_reg, n4y_reg;
    logic [DW-1:0] d4_reg;
    ctl_t          c4_reg;

    // stage 5
    logic [NW-1:0] lim;
    logic [NW-1:0] n5x_reg, n5y_reg;
    logic [DW-1:0] d5_reg;
    ctl_t          c5_reg;

    always_comb
    begin
        ax_next  = dir_x[15] ? 16'(-dir_x) : 16'(dir_x);
        ay_next  = dir_y[15] ? 16'(-dir_y) : 16'(dir_y);
        az_next  = dir_z[15] ? 16'(-dir_z) : 16'(dir_z);
        d_next   = (ONE_V > {1'b0, az_next}) ? 16'(ONE_V - {1'b0, az_next})
                                             : 16'({1'b0, az_next} - ONE_V);
        hid_next = $signed({dir_z[15], dir_z}) < -$signed({6'b0, tol});
    end

    assign wden_next = ONE_V + {1'b0, az_reg};
    assign l2_next   = {1'b0, a2x_reg} + {1'b0, a2y_reg};
    assign px_prod   = {1'b0, a2x3_reg} * l3_reg;
    assign py_prod   = {1'b0, a2y3_reg} * l3_reg;
    assign lim       = NW'({31'b0, d4_reg} * NW'(SAT_SQ));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            az_reg    <= az_next;
            d_reg     <= d_next;
            hid1_reg  <= hid_next;
            mode1_reg <= mode;
            zz1_reg   <= (dir_z == 16'sd0);
            nx1_reg   <= dir_x[15];
            ny1_reg   <= dir_y[15];

            a2x_reg   <= ax_reg * ax_reg;
            a2y_reg   <= ay_reg * ay_reg;
            d2_reg    <= d_reg * d_reg;
            wnx_reg   <= (NW'(ax_reg) << FRAC_BITS) + NW'(wden_next >> 1);
            wny_reg   <= (NW'(ay_reg) << FRAC_BITS) + NW'(wden_next >> 1);
            wden_reg  <= wden_next;
            hid2_reg  <= hid1_reg;
            mode2_reg <= mode1_reg;
            zz2_reg   <= zz1_reg;
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;

            l2_reg    <= l2_next;
            l3_reg    <= zz2_reg ? 33'(L3_AXIS) : l2_next + {1'b0, d2_reg};
            a2x3_reg  <= a2x_reg;
            a2y3_reg  <= a2y_reg;
            wnx3_reg  <= wnx_reg;
            wny3_reg  <= wny_reg;
            wden3_reg <= wden_reg;
            hid3_reg  <= hid2_reg;
            mode3_reg <= mode2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;

            n4x_reg       <= mode3_reg ? px_prod[NW-1:0] : wnx3_reg;
            n4y_reg       <= mode3_reg ? py_prod[NW-1:0] : wny3_reg;
            d4_reg        <= mode3_reg ? {l2_reg[31:0], 1'b0} : DW'(wden3_reg);
            c4_reg.hidden <= hid3_reg;
            c4_reg.mode   <= mode3_reg;
            c4_reg.axis   <= (l2_reg == '0);
            c4_reg.sat_x  <= 1'b0;
            c4_reg.sat_y  <= 1'b0;
            c4_reg.neg_x  <= nx3_reg;
            c4_reg.neg_y  <= ny3_reg;

            // result saturates when the quotient reaches the square of full scale
            n5x_reg       <= n4x_reg;
            n5y_reg       <= n4y_reg;
            d5_reg        <= d4_reg;
            c5_reg.hidden <= c4_reg.hidden;
            c5_reg.mode   <= c4_reg.mode;
            c5_reg.axis   <= c4_reg.axis;
            c5_reg.neg_x  <= c4_reg.neg_x;
            c5_reg.neg_y  <= c4_reg.neg_y;
            c5_reg.sat_x  <= n4x_reg >= lim;
            c5_reg.sat_y  <= n4y_reg >= lim;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_ctl   = c5_reg;
    assign num_x     = n5x_reg;
    assign num_y     = n5y_reg;
    assign den       = d5_reg;

endmodule

/* rtl/core/ppu_div_lane.sv */
// Restoring divider, one quotient bit per pipeline stage.
// Depends on ppu_pkg.
module ppu_div_lane
    import ppu_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [DW-1:0]  den,
    output logic [QW-1:0]  quo
);

    logic [DW-1:0] rem_reg [QW-1];
    logic [QW-1:0] low_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] r_in, d_in;
        logic [QW-1:0] l_in, q_in;
        logic [DW:0]   trial, diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_in = num[QW +: DW];
            assign l_in = num[QW-1:0];
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k-1];
            assign l_in = low_reg[k-1];
            assign d_in = den_reg[k-1];
            assign q_in = quo_reg[k-1];
        end

        assign trial = {r_in, l_in[QW-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = trial >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= {q_in[QW-2:0], ge};
            end
        end

        if (k < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    low_reg[k] <= {l_in[QW-2:0], 1'b0};
                    den_reg[k] <= d_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

/* rtl/core/ppu_sqrt_lane.sv */
// Digit-by-digit integer square root, one root bit per pipeline stage.
// Depends on ppu_pkg.
module ppu_sqrt_lane
    import ppu_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [QW-1:0]  rad,
    output logic [RW-1:0]  root
);

    logic [RMW-1:0]  rem_reg  [RW-1];
    logic [2*RW-1:0] val_reg  [RW-1];
    logic [RW-1:0]   root_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RMW-1:0]  r_in;
        logic [2*RW-1:0] v_in;
        logic [RW-1:0]   q_in;
        logic [RMW+1:0]  trial_rem, trial, diff;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign r_in = '0;
            assign v_in = (2*RW)'(rad);
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k-1];
            assign v_in = val_reg[k-1];
            assign q_in = root_reg[k-1];
        end

        assign trial_rem = {r_in, v_in[2*RW-1 -: 2]};
        assign trial     = (RMW+2)'({q_in, 2'b01});
        assign diff      = trial_rem - trial;
        assign ge        = trial_rem >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {q_in[RW-2:0], ge};
            end
        end

        if (k < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[RMW-1:0] : trial_rem[RMW-1:0];
                    val_reg[k] <= {v_in[2*RW-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

/* rtl/core/pole_projection_unit.sv */
// Pole projection top: config registers, front stages, divider and root lanes, output.
// Depends on ppu_pkg, ppu_front, ppu_div_lane, ppu_sqrt_lane.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  dir_x, dir_y, dir_z
//  m_axis    out        m_axis_tvalid / m_axis_tready  proj_x, proj_y; visible
//  cfg       in         cfg_we                         projection_mode, hide_tolerance
//
// One item per cycle while m_axis is not stalled; 5 front stages, 28 divider stages
// (one quotient bit each), 14 root stages (one root bit each), one output stage.
// Reset clears all valid bits and returns the config registers to their defaults.
// A stall on m_axis freezes every stage at once; s_axis_tready follows it.
module pole_projection_unit
    import ppu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // proj_x[15:0], proj_y[31:16]
    output logic         m_axis_tuser,   // visible
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_data
);

    logic          mode_reg;
    logic [10:0]   tol_reg;
    logic          en;

    logic          f_valid;
    ctl_t          f_ctl;
    logic [NW-1:0] f_num_x, f_num_y;
    logic [DW-1:0] f_den;

    logic          d_vld_reg [QW];
    ctl_t          d_ctl_reg [QW];
    logic [QW-1:0] quo_x, quo_y;
    side_t         side_next;

    logic          s_vld_reg [RW];
    side_t         s_side_reg [RW];
    logic [RW-1:0] root_x, root_y;

    logic [MW-1:0] mag_x, mag_y;
    logic          m_vld_reg;
    logic [15:0]   px_reg, py_reg;
    logic          vis_reg;
    side_t         fin;

    assign en            = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            tol_reg  <= 11'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[0];
                REG_TOL:  tol_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    ppu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .dir_x     (s_axis_tdata[15:0]),
        .dir_y     (s_axis_tdata[31:16]),
        .dir_z     (s_axis_tdata[47:32]),
        .mode      (mode_reg),
        .tol       (tol_reg),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .den       (f_den)
    );

    ppu_div_lane u_div_x (.clk(clk), .en(en), .num(f_num_x), .den(f_den), .quo(quo_x));
    ppu_div_lane u_div_y (.clk(clk), .en(en), .num(f_num_y), .den(f_den), .quo(quo_y));

    // side band alongside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                d_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            d_vld_reg[0] <= f_valid;
            for (int k = 1; k < QW; k++)
            begin
                d_vld_reg[k] <= d_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ctl_reg[0] <= f_ctl;
            for (int k = 1; k < QW; k++)
            begin
                d_ctl_reg[k] <= d_ctl_reg[k-1];
            end
        end
    end

    // clamp the stereographic quotient here; it skips the root
    always_comb
    begin
        side_next.c  = d_ctl_reg[QW-1];
        side_next.wx = (quo_x > QW'(SATV)) ? MW'(SATV) : quo_x[MW-1:0];
        side_next.wy = (quo_y > QW'(SATV)) ? MW'(SATV) : quo_y[MW-1:0];
    end

    ppu_sqrt_lane u_sqrt_x (.clk(clk), .en(en), .rad(quo_x), .root(root_x));
    ppu_sqrt_lane u_sqrt_y (.clk(clk), .en(en), .rad(quo_y), .root(root_y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RW; k++)
            begin
                s_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s_vld_reg[0] <= d_vld_reg[QW-1];
            for (int k = 1; k < RW; k++)
            begin
                s_vld_reg[k] <= s_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_side_reg[0] <= side_next;
            for (int k = 1; k < RW; k++)
            begin
                s_side_reg[k] <= s_side_reg[k-1];
            end
        end
    end

    assign fin = s_side_reg[RW-1];

    always_comb
    begin
        if (fin.c.hidden)
        begin
            mag_x = '0;
            mag_y = '0;
        end
        else if (!fin.c.mode)
        begin
            mag_x = fin.wx;
            mag_y = fin.wy;
        end
        else if (fin.c.axis)
        begin
            mag_x = '0;
            mag_y = '0;
        end
        else
        begin
            mag_x = fin.c.sat_x ? MW'(SATV) : MW'(root_x);
            mag_y = fin.c.sat_y ? MW'(SATV) : MW'(root_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= s_vld_reg[RW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= fin.c.neg_x ? 16'(-mag_x) : mag_x;
            py_reg  <= fin.c.neg_y ? 16'(-mag_y) : mag_y;
            vis_reg <= !fin.c.hidden;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {py_reg, px_reg};
    assign m_axis_tuser  = vis_reg;

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_vld_reg && !vis_reg |-> px_reg == '0 && py_reg == '0)
        else $error("hidden item with nonzero coordinates");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_vld_reg |-> $signed(px_reg) <= SATV && $signed(px_reg) >= -SATV
                   && $signed(py_reg) <= SATV && $signed(py_reg) >= -SATV)
        else $error("coordinate beyond full scale");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_vld_reg) |-> $past(s_vld_reg[RW-1]))
        else $error("output valid without an item in the last root stage");

endmodule
